/* design/ghp_pkg.sv */
// Shared types and constants for the hybrid gshare/perceptron branch predictor.
package ghp_pkg;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;
	localparam int WMAX_W     = 7;
	localparam int WMIN_W     = 8;
	localparam int LIM_W      = 10;

	localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_MAX = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_MIN = 1'd1;

	localparam logic MODE_PREDICT = 1'b0;
	localparam logic MODE_UPDATE  = 1'b1;

	localparam logic [1:0] CNT_MAX = 2'b11;
	localparam logic [1:0] CNT_MIN = 2'b00;

	typedef enum logic [3:0] {
		ST_CLEAR = 4'b0001,
		ST_IDLE  = 4'b0010,
		ST_READ  = 4'b0100,
		ST_EXEC  = 4'b1000
	} ghp_state_t;

	typedef struct packed {
		logic clear;
		logic load;
		logic rd;
		logic go;
	} ghp_cmd_t;

	typedef struct packed {
		logic clear_last;
		logic predict;
		logic out_stall;
	} ghp_stat_t;

endpackage

/* design/gshare_perceptron_hybrid_predictor.sv */
// Top level of the hybrid gshare/perceptron branch predictor with configuration registers.
// Each item goes through load, table read and execute, a split set by the registered read
// of the single-port tables; a predict item leaves its result in an output register and
// the next item is taken while it waits. After reset the tables are cleared one entry a
// cycle, 2^max(HISTORY_BITS, clog2(BUFFER_ENTRIES)) entries, while s_tready stays low.
module gshare_perceptron_hybrid_predictor
	import ghp_pkg::*;
#(
	parameter int HISTORY_BITS      = 8,
	parameter int BUFFER_ENTRIES    = 64,
	parameter int PERCEPTRON_INPUTS = 8,
	parameter int WEIGHT_BITS       = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [71:0]           s_tdata,   // pc, resolved_target, was_taken
	input  logic                  s_tuser,   // mode
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [39:0]           m_tdata,   // predicted_next_pc, predicted_taken
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [WMAX_W-1:0]        weight_max_q;
	logic signed [WMIN_W-1:0] weight_min_q;
	ghp_cmd_t                 cmd;
	ghp_stat_t                stat;
	logic [31:0]              next_pc;
	logic                     taken;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_max_q <= 7'd127;
			weight_min_q <= -8'sd128;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_WEIGHT_MAX: weight_max_q <= cfg_data[WMAX_W-1:0];
				CFG_WEIGHT_MIN: weight_min_q <= $signed(cfg_data[WMIN_W-1:0]);
				default: ;
			endcase
		end
	end

	ghp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	ghp_dp #(
		.HISTORY_BITS      (HISTORY_BITS),
		.BUFFER_ENTRIES    (BUFFER_ENTRIES),
		.PERCEPTRON_INPUTS (PERCEPTRON_INPUTS),
		.WEIGHT_BITS       (WEIGHT_BITS)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.stat              (stat),
		.mode              (s_tuser),
		.pc                (s_tdata[31:0]),
		.resolved_target   (s_tdata[63:32]),
		.was_taken         (s_tdata[64]),
		.weight_max        (weight_max_q),
		.weight_min        (weight_min_q),
		.out_valid         (m_tvalid),
		.out_ready         (m_tready),
		.predicted_next_pc (next_pc),
		.predicted_taken   (taken)
	);

	assign m_tdata = {7'd0, taken, next_pc};

endmodule

/* design/ghp_ctrl.sv */
// Sequencer for the predictor: table clearing, item load, table read, execute.
module ghp_ctrl
	import ghp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	output logic      s_tready,
	input  ghp_stat_t stat,
	output ghp_cmd_t  cmd
);

	ghp_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_CLEAR;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (stat.clear_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				cmd.rd = 1'b1;
				state_d = ST_EXEC;
			end
			ST_EXEC: begin
				if (!(stat.predict && stat.out_stall)) begin
					cmd.go = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

endmodule

/* design/ghp_dp.sv */
// Predictor datapath: history, counter tables, weight rows, target buffer, result register.
module ghp_dp
	import ghp_pkg::*;
#(
	parameter int HISTORY_BITS      = 8,
	parameter int BUFFER_ENTRIES    = 64,
	parameter int PERCEPTRON_INPUTS = 8,
	parameter int WEIGHT_BITS       = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  ghp_cmd_t                 cmd,
	output ghp_stat_t                stat,
	input  logic                     mode,
	input  logic [31:0]              pc,
	input  logic [31:0]              resolved_target,
	input  logic                     was_taken,
	input  logic [WMAX_W-1:0]        weight_max,
	input  logic signed [WMIN_W-1:0] weight_min,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [31:0]              predicted_next_pc,
	output logic                     predicted_taken
);

	localparam int H    = HISTORY_BITS;
	localparam int TBL  = 1 << H;
	localparam int IW   = $clog2(BUFFER_ENTRIES);
	localparam int TW   = 30 - IW;
	localparam int P    = PERCEPTRON_INPUTS;
	localparam int WB   = WEIGHT_BITS;
	localparam int RW   = P * WB;
	localparam int BW   = 1 + TW + 32;
	localparam int CLW  = (H > IW) ? H : IW;
	localparam int XW   = (H + 1 > P) ? H + 1 : P;
	localparam int SW   = WB + 4;
	localparam logic signed [LIM_W-1:0] HI = LIM_W'((1 << (WB - 1)) - 1);
	localparam logic signed [LIM_W-1:0] LO = -HI - LIM_W'(1);

	logic [1:0]    pht_mem [TBL];
	logic [2:0]    chs_mem [TBL];
	logic [RW-1:0] wgt_mem [TBL];
	logic [BW-1:0] btb_mem [BUFFER_ENTRIES];

	logic          mode_q, taken_q;
	logic [31:0]   pc_q, target_q;
	logic [H-1:0]  hist_q;
	logic [CLW-1:0] clr_q;
	logic [1:0]    pht_rd_q;
	logic [2:0]    chs_rd_q;
	logic [RW-1:0] wgt_rd_q;
	logic [BW-1:0] btb_rd_q;
	logic          out_valid_q, out_taken_q;
	logic [31:0]   out_pc_q;

	logic [29:0]   word;
	logic [H-1:0]  sel, pht_idx;
	logic [IW-1:0] bidx;
	logic [TW-1:0] tag;
	logic [XW-1:0] inx;
	logic [P-1:0]  inb;
	logic signed [SW-1:0] sum;
	logic          g_guess, p_guess, use_p, chosen, correct, up, hit;
	logic [1:0]    chs_new, pht_new;
	logic [RW-1:0] wgt_new;
	logic [31:0]   pc_plus4, next_pc;
	logic signed [LIM_W-1:0] emax, emin, wmax_x, wmin_x, w;
	logic          do_upd, do_pred;

	assign word     = pc_q[31:2];
	assign sel      = word[H-1:0];
	assign pht_idx  = sel ^ hist_q;
	assign bidx     = word[IW-1:0];
	assign tag      = word[29:IW];
	assign inx      = XW'({hist_q, 1'b1});
	assign inb      = inx[P-1:0];
	assign pc_plus4 = pc_q + 32'd4;
	assign do_upd   = cmd.go && (mode_q == MODE_UPDATE);
	assign do_pred  = cmd.go && (mode_q == MODE_PREDICT);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q   <= mode;
			pc_q     <= pc;
			target_q <= resolved_target;
			taken_q  <= was_taken;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			hist_q <= '0;
		end else begin
			if (cmd.clear) clr_q <= clr_q + CLW'(1);
			if (do_upd) hist_q <= {hist_q[H-2:0], taken_q};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd) pht_rd_q <= pht_mem[pht_idx];
		if (cmd.clear) pht_mem[clr_q[H-1:0]] <= '0;
		else if (do_upd) pht_mem[pht_idx] <= pht_new;
	end

	always_ff @(posedge clk) begin
		if (cmd.rd) chs_rd_q <= chs_mem[sel];
		if (cmd.clear) chs_mem[clr_q[H-1:0]] <= '0;
		else if (do_pred) chs_mem[sel] <= {use_p, chs_rd_q[1:0]};
		else if (do_upd) chs_mem[sel] <= {chs_rd_q[2], chs_new};
	end

	always_ff @(posedge clk) begin
		if (cmd.rd) wgt_rd_q <= wgt_mem[sel];
		if (cmd.clear) wgt_mem[clr_q[H-1:0]] <= '0;
		else if (do_upd && (chosen != taken_q)) wgt_mem[sel] <= wgt_new;
	end

	always_ff @(posedge clk) begin
		if (cmd.rd) btb_rd_q <= btb_mem[bidx];
		if (cmd.clear) btb_mem[clr_q[IW-1:0]] <= '0;
		else if (do_upd && taken_q) btb_mem[bidx] <= {1'b1, tag, target_q};
	end

	always_comb begin
		sum = '0;
		for (int i = 0; i < P; i++) begin
			if (inb[i]) sum = sum + SW'($signed(wgt_rd_q[i*WB +: WB]));
		end
	end

	assign g_guess = pht_rd_q[1];
	assign p_guess = ~sum[SW-1];
	assign use_p   = (mode_q == MODE_PREDICT) ? chs_rd_q[1] : chs_rd_q[2];
	assign chosen  = use_p ? p_guess : g_guess;
	assign correct = (chosen == taken_q);
	assign up      = use_p ? correct : !correct;

	always_comb begin
		chs_new = chs_rd_q[1:0];
		if (up) begin
			if (chs_rd_q[1:0] != CNT_MAX) chs_new = chs_rd_q[1:0] + 2'd1;
		end else begin
			if (chs_rd_q[1:0] != CNT_MIN) chs_new = chs_rd_q[1:0] - 2'd1;
		end
		pht_new = pht_rd_q;
		if (taken_q) begin
			if (pht_rd_q != CNT_MAX) pht_new = pht_rd_q + 2'd1;
		end else begin
			if (pht_rd_q != CNT_MIN) pht_new = pht_rd_q - 2'd1;
		end
	end

	assign wmax_x = LIM_W'($signed({1'b0, weight_max}));
	assign wmin_x = LIM_W'(weight_min);

	always_comb begin
		emax = (wmax_x < HI) ? wmax_x : HI;
		emin = (wmin_x > LO) ? wmin_x : LO;
		if (emin > HI) emin = HI;
		wgt_new = '0;
		w = '0;
		for (int i = 0; i < P; i++) begin
			w = LIM_W'($signed(wgt_rd_q[i*WB +: WB]));
			if (inb[i]) w = taken_q ? w + LIM_W'(1) : w - LIM_W'(1);
			if (w > emax) w = emax;
			if (w < emin) w = emin;
			wgt_new[i*WB +: WB] = w[WB-1:0];
		end
	end

	assign hit     = btb_rd_q[BW-1] && (btb_rd_q[32 +: TW] == tag);
	assign next_pc = (chosen && hit) ? btb_rd_q[31:0] : pc_plus4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (do_pred) out_valid_q <= 1'b1;
		else if (out_ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (do_pred) begin
			out_pc_q    <= next_pc;
			out_taken_q <= chosen;
		end
	end

	assign stat.clear_last   = &clr_q;
	assign stat.predict      = (mode_q == MODE_PREDICT);
	assign stat.out_stall    = out_valid_q && !out_ready;
	assign out_valid         = out_valid_q;
	assign predicted_next_pc = out_pc_q;
	assign predicted_taken   = out_taken_q;

endmodule
